// ----- sv/vpwwt_pkg.sv -----
// Shared types, codes and default sizes for the VRAM write-watch table.
package vpwwt_pkg;

    // Default geometry
    localparam int PageCountDef    = 2048;
    localparam int PageShiftDef    = 12;
    localparam int SlotsPerPageDef = 8;
    localparam int HandleCountDef  = 64;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_LOCK   = 2'd0,
        OP_UNLOCK = 2'd1,
        OP_WRITE  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_OUTSIDE    = 3'd1,
        ST_NO_HANDLE  = 3'd2,
        ST_SLOTS_FULL = 3'd3,
        ST_NOT_ACTIVE = 3'd4
    } t_status;

    typedef struct packed {
        t_op         operation;
        logic [31:0] start_offset;
        logic [31:0] end_offset;
        logic [5:0]  handle_in;
        logic [31:0] write_offset;
    } t_req;

    typedef struct packed {
        t_status    status;
        logic [5:0] handle_out;
        logic       handle_valid;
        logic       end_clamped;
        logic       start_reset;
        logic       page_was_protected;
        logic       last;
    } t_res;

    // Sequencer states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_L_RD,
        S_L_CHK,
        S_C_RD,
        S_C_WR,
        S_L_FIN,
        S_R_RANGE,
        S_R_LOAD,
        S_R_RD,
        S_R_UPD,
        S_R_FIN,
        S_W_RD,
        S_W_LOAD,
        S_W_SLOT,
        S_W_CLR,
        S_EMIT,
        S_EMIT_H
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic    take;
        logic    set_code;
        t_status code;
        logic    h_free;
        logic    page_inc;
        logic    page_lo;
        logic    row_commit;
        logic    row_release;
        logic    row_zero_w;
        logic    row_zero_clr;
        logic    range_load;
        logic    range_store;
        logic    active_clr;
        logic    hits_load;
        logic    hit_pop;
        logic    emit;
        logic    emit_handle;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic no_free;
        logic handle_bad;
        logic outside;
        logic row_full;
        logic pg_last;
        logic clr_last;
        logic hits_any;
        logic hit_active;
        logic any_hit;
        logic out_free;
    } t_stat;

endpackage

// ----- sv/vram_page_write_watch_table_unit.sv -----
// Top level of the VRAM page write-watch table.
//
// After reset the unit sweeps the page slot and protection memories, one page
// per cycle, over all PAGE_COUNT pages before it takes its first request. A
// request is taken only when the sequencer is idle; the one read and one write
// port of the page table set the pace. An out-of-range write, a lock refused
// for lack of a free handle or an undefined operation goes from decode straight
// to its result; a lock refused for a full page ends its check pass there. A
// lock reads and checks each covered page, then reads and fills each one. An
// unlock reads and releases each of the handle's pages. A write in VRAM reads
// its page and, for each handle on it, issues a result and, while the handle
// is active, releases its pages; then it clears the page. Results leave through
// an output register, so the next request can be taken while the last result
// still waits downstream.
module vram_page_write_watch_table_unit #(
    parameter int PAGE_COUNT     = vpwwt_pkg::PageCountDef,
    parameter int PAGE_SHIFT     = vpwwt_pkg::PageShiftDef,
    parameter int SLOTS_PER_PAGE = vpwwt_pkg::SlotsPerPageDef,
    parameter int HANDLE_COUNT   = vpwwt_pkg::HandleCountDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  vpwwt_pkg::t_req i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output vpwwt_pkg::t_res o_out_data
);

    vpwwt_pkg::t_cmd  w_cmd;
    vpwwt_pkg::t_stat w_stat;

    // Sequencer
    vpwwt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Tables and result register
    vpwwt_dp #(
        .PAGE_COUNT     (PAGE_COUNT),
        .PAGE_SHIFT     (PAGE_SHIFT),
        .SLOTS_PER_PAGE (SLOTS_PER_PAGE),
        .HANDLE_COUNT   (HANDLE_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- sv/vpwwt_ctrl.sv -----
// Sequencer for lock, unlock and write requests of the write-watch table.
module vpwwt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  vpwwt_pkg::t_stat i_stat,
    output vpwwt_pkg::t_cmd  o_cmd
);

    vpwwt_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vpwwt_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vpwwt_pkg::S_CLEAR: begin
                if (i_stat.clr_last) n_state = vpwwt_pkg::S_IDLE;
            end
            vpwwt_pkg::S_IDLE: begin
                if (i_in_valid) n_state = vpwwt_pkg::S_DECODE;
            end
            vpwwt_pkg::S_DECODE: begin
                unique case (i_stat.op)
                    vpwwt_pkg::OP_LOCK:
                        n_state = i_stat.no_free ? vpwwt_pkg::S_EMIT : vpwwt_pkg::S_L_RD;
                    vpwwt_pkg::OP_UNLOCK:
                        n_state = i_stat.handle_bad ? vpwwt_pkg::S_EMIT
                                                    : vpwwt_pkg::S_R_RANGE;
                    vpwwt_pkg::OP_WRITE:
                        n_state = i_stat.outside ? vpwwt_pkg::S_EMIT : vpwwt_pkg::S_W_RD;
                    default: n_state = vpwwt_pkg::S_EMIT;
                endcase
            end
            vpwwt_pkg::S_L_RD: n_state = vpwwt_pkg::S_L_CHK;
            vpwwt_pkg::S_L_CHK: begin
                if (i_stat.row_full) n_state = vpwwt_pkg::S_EMIT;
                else if (i_stat.pg_last) n_state = vpwwt_pkg::S_C_RD;
                else n_state = vpwwt_pkg::S_L_RD;
            end
            vpwwt_pkg::S_C_RD: n_state = vpwwt_pkg::S_C_WR;
            vpwwt_pkg::S_C_WR: begin
                n_state = i_stat.pg_last ? vpwwt_pkg::S_L_FIN : vpwwt_pkg::S_C_RD;
            end
            vpwwt_pkg::S_L_FIN:   n_state = vpwwt_pkg::S_EMIT_H;
            vpwwt_pkg::S_R_RANGE: n_state = vpwwt_pkg::S_R_LOAD;
            vpwwt_pkg::S_R_LOAD:  n_state = vpwwt_pkg::S_R_RD;
            vpwwt_pkg::S_R_RD:    n_state = vpwwt_pkg::S_R_UPD;
            vpwwt_pkg::S_R_UPD: begin
                n_state = i_stat.pg_last ? vpwwt_pkg::S_R_FIN : vpwwt_pkg::S_R_RD;
            end
            vpwwt_pkg::S_R_FIN: begin
                n_state = (i_stat.op == vpwwt_pkg::OP_WRITE) ? vpwwt_pkg::S_W_SLOT
                                                             : vpwwt_pkg::S_EMIT;
            end
            vpwwt_pkg::S_W_RD:   n_state = vpwwt_pkg::S_W_LOAD;
            vpwwt_pkg::S_W_LOAD: n_state = vpwwt_pkg::S_W_SLOT;
            vpwwt_pkg::S_W_SLOT: begin
                if (!i_stat.hits_any) n_state = vpwwt_pkg::S_W_CLR;
                else if (i_stat.out_free && i_stat.hit_active) n_state = vpwwt_pkg::S_R_RANGE;
            end
            vpwwt_pkg::S_W_CLR: begin
                n_state = i_stat.any_hit ? vpwwt_pkg::S_IDLE : vpwwt_pkg::S_EMIT;
            end
            vpwwt_pkg::S_EMIT, vpwwt_pkg::S_EMIT_H: begin
                if (i_stat.out_free) n_state = vpwwt_pkg::S_IDLE;
            end
            default: n_state = vpwwt_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.code = vpwwt_pkg::ST_OK;
        o_in_ready = 1'b0;
        unique case (r_state)
            vpwwt_pkg::S_CLEAR: begin
                o_cmd.row_zero_clr = 1'b1;
                o_cmd.page_inc     = 1'b1;
            end
            vpwwt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            vpwwt_pkg::S_DECODE: begin
                unique case (i_stat.op)
                    vpwwt_pkg::OP_LOCK: begin
                        o_cmd.h_free   = !i_stat.no_free;
                        o_cmd.set_code = i_stat.no_free;
                        o_cmd.code     = vpwwt_pkg::ST_NO_HANDLE;
                    end
                    vpwwt_pkg::OP_UNLOCK: begin
                        o_cmd.set_code = i_stat.handle_bad;
                        o_cmd.code     = vpwwt_pkg::ST_NOT_ACTIVE;
                    end
                    vpwwt_pkg::OP_WRITE: begin
                        o_cmd.set_code = i_stat.outside;
                        o_cmd.code     = vpwwt_pkg::ST_OUTSIDE;
                    end
                    default: ;
                endcase
            end
            vpwwt_pkg::S_L_CHK: begin
                o_cmd.set_code = i_stat.row_full;
                o_cmd.code     = vpwwt_pkg::ST_SLOTS_FULL;
                o_cmd.page_lo  = !i_stat.row_full && i_stat.pg_last;
                o_cmd.page_inc = !i_stat.row_full && !i_stat.pg_last;
            end
            vpwwt_pkg::S_C_WR: begin
                o_cmd.row_commit = 1'b1;
                o_cmd.page_inc   = !i_stat.pg_last;
            end
            vpwwt_pkg::S_L_FIN:  o_cmd.range_store = 1'b1;
            vpwwt_pkg::S_R_LOAD: o_cmd.range_load  = 1'b1;
            vpwwt_pkg::S_R_UPD: begin
                o_cmd.row_release = 1'b1;
                o_cmd.page_inc    = !i_stat.pg_last;
            end
            vpwwt_pkg::S_R_FIN:  o_cmd.active_clr = 1'b1;
            vpwwt_pkg::S_W_LOAD: o_cmd.hits_load  = 1'b1;
            vpwwt_pkg::S_W_SLOT: o_cmd.hit_pop = i_stat.hits_any && i_stat.out_free;
            vpwwt_pkg::S_W_CLR:  o_cmd.row_zero_w = 1'b1;
            vpwwt_pkg::S_EMIT:   o_cmd.emit = i_stat.out_free;
            vpwwt_pkg::S_EMIT_H: begin
                o_cmd.emit        = i_stat.out_free;
                o_cmd.emit_handle = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ----- sv/vpwwt_dp.sv -----
// Datapath: page slot and protection memories, handle ranges, counters and result register.
module vpwwt_dp #(
    parameter int PAGE_COUNT     = vpwwt_pkg::PageCountDef,
    parameter int PAGE_SHIFT     = vpwwt_pkg::PageShiftDef,
    parameter int SLOTS_PER_PAGE = vpwwt_pkg::SlotsPerPageDef,
    parameter int HANDLE_COUNT   = vpwwt_pkg::HandleCountDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vpwwt_pkg::t_req   i_in_data,
    input  vpwwt_pkg::t_cmd   i_cmd,
    output vpwwt_pkg::t_stat  o_stat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output vpwwt_pkg::t_res   o_out_data
);

    localparam int PW  = $clog2(PAGE_COUNT);
    localparam int HIW = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;
    localparam int EW  = HIW + 1;
    localparam logic [32:0] VramBytes = 33'(PAGE_COUNT) << PAGE_SHIFT;
    localparam logic [PW-1:0] PageMax = PW'(PAGE_COUNT - 1);

    typedef logic [SLOTS_PER_PAGE-1:0][EW-1:0] t_row;

    // Storage
    t_row              r_row_mem [PAGE_COUNT];
    logic              r_prot_mem [PAGE_COUNT];
    logic [2*PW-1:0]   r_range_mem [HANDLE_COUNT];
    t_row              r_row_q;
    logic              r_prot_q;
    logic [2*PW-1:0]   r_range_q;

    // Working registers
    vpwwt_pkg::t_op     r_op;
    vpwwt_pkg::t_status r_code;
    logic [PW-1:0]      r_page, r_lo, r_hi, r_wpage;
    logic [HIW-1:0]     r_h;
    logic               r_h_range_bad;
    logic               r_ec, r_sr, r_pp, r_outside, r_any;
    logic [SLOTS_PER_PAGE-1:0] r_hits;
    t_row               r_hrow;
    logic [HANDLE_COUNT-1:0]   r_active;
    logic               r_out_valid;
    vpwwt_pkg::t_res    r_out;

    // Request decode: clamp lock region, locate write page
    logic [32:0]   w_end_c;
    logic          w_ec, w_sr;
    logic [31:0]   w_start_c;
    logic [PW-1:0] w_lo, w_hi, w_wpage;
    logic          w_outside;
    always_comb begin
        w_ec      = {1'b0, i_in_data.end_offset} >= VramBytes;
        w_end_c   = w_ec ? (VramBytes - 33'd1) : {1'b0, i_in_data.end_offset};
        w_sr      = {1'b0, i_in_data.start_offset} > w_end_c;
        w_start_c = w_sr ? 32'd0 : i_in_data.start_offset;
        w_lo      = PW'(w_start_c >> PAGE_SHIFT);
        w_hi      = PW'(w_end_c >> PAGE_SHIFT);
        w_outside = {1'b0, i_in_data.write_offset} >= VramBytes;
        w_wpage   = PW'(i_in_data.write_offset >> PAGE_SHIFT);
    end

    // Lowest free handle
    logic           w_no_free;
    logic [HIW-1:0] w_free_h;
    always_comb begin
        logic found;
        found    = 1'b0;
        w_free_h = '0;
        for (int h = 0; h < HANDLE_COUNT; h++) begin
            if (!r_active[h] && !found) begin
                w_free_h = HIW'(h);
                found    = 1'b1;
            end
        end
        w_no_free = !found;
    end

    // Row operations: full check, insert, remove handle
    logic w_row_full;
    t_row w_row_ins, w_row_rel;
    always_comb begin
        logic placed;
        placed     = 1'b0;
        w_row_full = 1'b1;
        w_row_ins  = r_row_q;
        w_row_rel  = r_row_q;
        for (int s = 0; s < SLOTS_PER_PAGE; s++) begin
            if (!r_row_q[s][EW-1]) begin
                w_row_full = 1'b0;
                if (!placed) begin
                    w_row_ins[s] = {1'b1, r_h};
                    placed       = 1'b1;
                end
            end
            if (r_row_q[s][EW-1] && (r_row_q[s][HIW-1:0] == r_h)) begin
                w_row_rel[s] = '0;
            end
        end
    end

    // Next hit of the written page in slot order
    logic [HIW-1:0]            w_hit_h;
    logic [SLOTS_PER_PAGE-1:0] w_hits_rest;
    always_comb begin
        logic found;
        found       = 1'b0;
        w_hit_h     = '0;
        w_hits_rest = r_hits;
        for (int s = 0; s < SLOTS_PER_PAGE; s++) begin
            if (r_hits[s] && !found) begin
                w_hit_h        = r_hrow[s][HIW-1:0];
                w_hits_rest[s] = 1'b0;
                found          = 1'b1;
            end
        end
    end

    logic w_out_free;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Memory write port selection
    logic          w_row_we, w_prot_we, w_prot_d;
    logic [PW-1:0] w_wr_addr;
    t_row          w_row_d;
    always_comb begin
        w_row_we  = i_cmd.row_commit || i_cmd.row_release || i_cmd.row_zero_w
                 || i_cmd.row_zero_clr;
        w_prot_we = i_cmd.row_commit || i_cmd.row_zero_w || i_cmd.row_zero_clr;
        w_prot_d  = i_cmd.row_commit;
        w_wr_addr = i_cmd.row_zero_w ? r_wpage : r_page;
        if (i_cmd.row_commit) w_row_d = w_row_ins;
        else if (i_cmd.row_release) w_row_d = w_row_rel;
        else w_row_d = '0;
    end

    // Page slot and protection memories
    always_ff @(posedge i_clk) begin
        if (w_row_we) r_row_mem[w_wr_addr] <= w_row_d;
        if (w_prot_we) r_prot_mem[w_wr_addr] <= w_prot_d;
        r_row_q  <= r_row_mem[r_page];
        r_prot_q <= r_prot_mem[r_page];
    end

    // Handle page-range memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.range_store) r_range_mem[r_h] <= {r_lo, r_hi};
        r_range_q <= r_range_mem[r_h];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page      <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_page <= (i_in_data.operation == vpwwt_pkg::OP_WRITE) ? w_wpage : w_lo;
            end else if (i_cmd.page_lo) begin
                r_page <= r_lo;
            end else if (i_cmd.range_load) begin
                r_page <= r_range_q[2*PW-1:PW];
            end else if (i_cmd.page_inc) begin
                r_page <= PW'(r_page + 1'b1);
            end
            if (i_cmd.range_store) r_active[r_h] <= 1'b1;
            if (i_cmd.active_clr) r_active[r_h] <= 1'b0;
            if (i_cmd.emit || i_cmd.hit_pop) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Request and work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op          <= i_in_data.operation;
            r_code        <= vpwwt_pkg::ST_OK;
            r_lo          <= w_lo;
            r_hi          <= w_hi;
            r_wpage       <= w_wpage;
            r_outside     <= w_outside;
            r_h           <= HIW'(i_in_data.handle_in);
            r_h_range_bad <= 32'(i_in_data.handle_in) >= 32'(HANDLE_COUNT);
            r_ec          <= (i_in_data.operation == vpwwt_pkg::OP_LOCK) && w_ec;
            r_sr          <= (i_in_data.operation == vpwwt_pkg::OP_LOCK) && w_sr;
            r_pp          <= 1'b0;
            r_any         <= 1'b0;
            r_hits        <= '0;
        end else begin
            if (i_cmd.set_code) r_code <= i_cmd.code;
            if (i_cmd.h_free) r_h <= w_free_h;
            if (i_cmd.range_load) begin
                r_lo <= r_range_q[2*PW-1:PW];
                r_hi <= r_range_q[PW-1:0];
            end
            if (i_cmd.hits_load) begin
                r_pp   <= r_prot_q;
                r_hrow <= r_row_q;
                for (int s = 0; s < SLOTS_PER_PAGE; s++) r_hits[s] <= r_row_q[s][EW-1];
            end
            if (i_cmd.hit_pop) begin
                r_h    <= w_hit_h;
                r_hits <= w_hits_rest;
                r_any  <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit || i_cmd.hit_pop) begin
            r_out.status             <= r_code;
            r_out.handle_out         <= i_cmd.hit_pop ? 6'(w_hit_h)
                                      : (i_cmd.emit_handle ? 6'(r_h) : 6'd0);
            r_out.handle_valid       <= i_cmd.hit_pop || i_cmd.emit_handle;
            r_out.end_clamped        <= r_ec;
            r_out.start_reset        <= r_sr;
            r_out.page_was_protected <= r_pp;
            r_out.last               <= i_cmd.hit_pop ? (w_hits_rest == '0) : 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status to the sequencer
    always_comb begin
        o_stat.op         = r_op;
        o_stat.no_free    = w_no_free;
        o_stat.handle_bad = r_h_range_bad ? 1'b1 : !r_active[r_h];
        o_stat.outside    = r_outside;
        o_stat.row_full   = w_row_full;
        o_stat.pg_last    = r_page == r_hi;
        o_stat.clr_last   = r_page == PageMax;
        o_stat.hits_any   = r_hits != '0;
        o_stat.hit_active = r_active[w_hit_h];
        o_stat.any_hit    = r_any;
        o_stat.out_free   = w_out_free;
    end

    // Checks
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.hit_pop) |-> w_out_free)
        else $error("result issued while output register busy");
    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.row_commit |-> !w_row_full)
        else $error("handle inserted into a full page");
    a_pop_has_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hit_pop |-> (r_hits != '0))
        else $error("hit popped from empty list");
    a_store_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.range_store |=> r_active[$past(r_h)])
        else $error("locked handle not marked active");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the VRAM page write-watch table unit.
module tb;

    localparam int PAGES     = vpwwt_pkg::PageCountDef;
    localparam int SHIFT     = vpwwt_pkg::PageShiftDef;
    localparam int SLOTS     = vpwwt_pkg::SlotsPerPageDef;
    localparam int HANDLES   = vpwwt_pkg::HandleCountDef;
    localparam int LIMIT     = 1500000;
    localparam int DRAIN     = 60;
    localparam int N_RANDOM  = 340;

    // Watch-table predictor and queue of expected results
    class watch_scoreboard;
        logic [6:0]  slot_tab [PAGES][SLOTS];   // 0 empty, else handle + 1
        bit          protect  [PAGES];
        int          first_pg [HANDLES];
        int          last_pg  [HANDLES];
        bit          active   [HANDLES];
        vpwwt_pkg::t_res expected_results [$];
        int          errors;
        int          n_results;
        int          n_hits;

        function new();
            foreach (slot_tab[p, s]) slot_tab[p][s] = '0;
            foreach (protect[p]) protect[p] = 1'b0;
            foreach (active[h]) begin
                active[h] = 1'b0;
                first_pg[h] = 0;
                last_pg[h] = 0;
            end
            errors = 0;
            n_results = 0;
            n_hits = 0;
        endfunction

        function vpwwt_pkg::t_res make(vpwwt_pkg::t_status st, int h, bit hv, bit ec, bit sr,
                                       bit pp, bit lst);
            vpwwt_pkg::t_res r;
            r.status = st;
            r.handle_out = h[5:0];
            r.handle_valid = hv;
            r.end_clamped = ec;
            r.start_reset = sr;
            r.page_was_protected = pp;
            r.last = lst;
            return r;
        endfunction

        // Append one expected result
        function void add_expected(vpwwt_pkg::t_res r);
            expected_results.insert(expected_results.size(), r);
        endfunction

        // Remove a handle from every page of its range and free it
        function void drop_handle(int h);
            int hi;
            hi = (last_pg[h] >= PAGES) ? PAGES - 1 : last_pg[h];
            for (int p = first_pg[h]; p <= hi; p++)
                for (int s = 0; s < SLOTS; s++)
                    if (slot_tab[p][s] == 7'(h + 1)) slot_tab[p][s] = '0;
            active[h] = 1'b0;
        endfunction

        function void lock_region(vpwwt_pkg::t_req r);
            logic [32:0] st, en;
            bit ec, sr, full;
            int lo, hi, h;
            st = {1'b0, r.start_offset};
            en = {1'b0, r.end_offset};
            ec = 1'b0;
            sr = 1'b0;
            full = 1'b0;
            if (en > 33'((PAGES << SHIFT) - 1)) begin
                en = 33'((PAGES << SHIFT) - 1);
                ec = 1'b1;
            end
            if (st > en) begin
                st = '0;
                sr = 1'b1;
            end
            lo = int'(st >> SHIFT);
            hi = int'(en >> SHIFT);
            h = 0;
            while (h < HANDLES && active[h]) h++;
            if (h >= HANDLES) begin
                add_expected(make(vpwwt_pkg::ST_NO_HANDLE, 0, 0, ec, sr, 0, 1));
                return;
            end
            for (int p = lo; p <= hi; p++) begin
                bit any_free;
                any_free = 1'b0;
                for (int s = 0; s < SLOTS; s++) if (slot_tab[p][s] == '0) any_free = 1'b1;
                if (!any_free) full = 1'b1;
            end
            if (full) begin
                add_expected(make(vpwwt_pkg::ST_SLOTS_FULL, 0, 0, ec, sr, 0, 1));
                return;
            end
            for (int p = lo; p <= hi; p++) begin
                protect[p] = 1'b1;
                for (int s = 0; s < SLOTS; s++)
                    if (slot_tab[p][s] == '0) begin
                        slot_tab[p][s] = 7'(h + 1);
                        break;
                    end
            end
            first_pg[h] = lo;
            last_pg[h] = hi;
            active[h] = 1'b1;
            add_expected(make(vpwwt_pkg::ST_OK, h, 1, ec, sr, 0, 1));
        endfunction

        function void write_page(vpwwt_pkg::t_req r);
            int p, n, hits[$];
            bit pp;
            if (r.write_offset >= 32'(PAGES << SHIFT)) begin
                add_expected(make(vpwwt_pkg::ST_OUTSIDE, 0, 0, 0, 0, 0, 1));
                return;
            end
            p = int'(r.write_offset >> SHIFT);
            pp = protect[p];
            for (int s = 0; s < SLOTS; s++)
                if (slot_tab[p][s] != '0) begin
                    int h;
                    h = int'(slot_tab[p][s]) - 1;
                    hits.insert(hits.size(), h);
                    if (active[h]) drop_handle(h);
                end
            for (int s = 0; s < SLOTS; s++) slot_tab[p][s] = '0;
            protect[p] = 1'b0;
            n = hits.size();
            n_hits += n;
            if (n == 0) add_expected(make(vpwwt_pkg::ST_OK, 0, 0, 0, 0, pp, 1));
            for (int k = 0; k < n; k++)
                add_expected(make(vpwwt_pkg::ST_OK, hits[k], 1, 0, 0, pp, k == n - 1));
        endfunction

        // Note an accepted request
        function void note_request(vpwwt_pkg::t_req r);
            case (r.operation)
                vpwwt_pkg::OP_LOCK:   lock_region(r);
                vpwwt_pkg::OP_UNLOCK: begin
                    if (!active[r.handle_in])
                        add_expected(make(vpwwt_pkg::ST_NOT_ACTIVE, 0, 0, 0, 0, 0, 1));
                    else begin
                        drop_handle(r.handle_in);
                        add_expected(make(vpwwt_pkg::ST_OK, 0, 0, 0, 0, 0, 1));
                    end
                end
                vpwwt_pkg::OP_WRITE:  write_page(r);
                default:   add_expected(make(vpwwt_pkg::ST_OK, 0, 0, 0, 0, 0, 1));
            endcase
        endfunction

        // Check one accepted result against the oldest expectation
        function void check_result(vpwwt_pkg::t_res got);
            vpwwt_pkg::t_res exp;
            n_results++;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            exp = expected_results.pop_front();
            if (got.status !== exp.status || got.handle_out !== exp.handle_out ||
                got.handle_valid !== exp.handle_valid || got.end_clamped !== exp.end_clamped ||
                got.start_reset !== exp.start_reset ||
                got.page_was_protected !== exp.page_was_protected || got.last !== exp.last) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch #%0d: expected %p, got %p", errors, exp, got);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic i_clk, i_rst_n, i_in_valid, o_in_ready, o_out_valid, i_out_ready;
    vpwwt_pkg::t_req i_in_data;
    vpwwt_pkg::t_res o_out_data;

    watch_scoreboard sb;
    bit   calm;
    int   cycles;
    int   out_stall;
    int   n_sent, n_lock, n_unlock, n_write;

    vram_page_write_watch_table_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Cycle watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result sink with random back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_data);
            out_stall = calm ? 0 : $urandom_range(0, 8);
        end
        if (out_stall > 0) begin
            i_out_ready <= 1'b0;
            out_stall--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Send one request after a random gap and wait for it to be taken
    task automatic send(vpwwt_pkg::t_req r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(r);
        n_sent++;
        case (r.operation)
            vpwwt_pkg::OP_LOCK:   n_lock++;
            vpwwt_pkg::OP_UNLOCK: n_unlock++;
            vpwwt_pkg::OP_WRITE:  n_write++;
            default:   ;
        endcase
    endtask

    function automatic vpwwt_pkg::t_req noise_req(vpwwt_pkg::t_op op);
        vpwwt_pkg::t_req r;
        r.operation = op;
        r.start_offset = $urandom();
        r.end_offset = $urandom();
        r.handle_in = 6'($urandom());
        r.write_offset = $urandom();
        return r;
    endfunction

    task automatic do_lock(logic [31:0] s, logic [31:0] e);
        vpwwt_pkg::t_req r;
        r = noise_req(vpwwt_pkg::OP_LOCK);
        r.start_offset = s;
        r.end_offset = e;
        send(r);
    endtask

    task automatic do_unlock(logic [5:0] h);
        vpwwt_pkg::t_req r;
        r = noise_req(vpwwt_pkg::OP_UNLOCK);
        r.handle_in = h;
        send(r);
    endtask

    task automatic do_write(logic [31:0] o);
        vpwwt_pkg::t_req r;
        r = noise_req(vpwwt_pkg::OP_WRITE);
        r.write_offset = o;
        send(r);
    endtask

    // Hold the sender until every expected result has come, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // One random request, mostly small regions in the low pages
    task automatic random_request();
        int sel, lo, hi, pick;
        logic [31:0] s, e;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            lo = $urandom_range(0, 47);
            hi = lo + $urandom_range(0, 3);
            s = 32'(lo << SHIFT) | $urandom_range(0, 4095);
            e = 32'(hi << SHIFT) | $urandom_range(0, 4095);
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                do_lock(e, s);
            end else if (pick < 16) begin
                do_lock(32'((PAGES - 1 - $urandom_range(0, 3)) << SHIFT) | $urandom_range(0, 4095),
                        $urandom() | 32'h0080_0000);
            end else if (pick < 18) begin
                do_lock($urandom(), $urandom());
            end else begin
                do_lock(s, e);
            end
        end else if (sel < 65) begin
            pick = $urandom_range(0, HANDLES - 1);
            if ($urandom_range(0, 9) < 7)
                for (int k = 0; k < HANDLES; k++)
                    if (sb.active[(pick + k) % HANDLES]) begin
                        pick = (pick + k) % HANDLES;
                        break;
                    end
            do_unlock(6'(pick));
        end else if (sel < 95) begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                do_write(32'($urandom_range(0, 47) << SHIFT) | $urandom_range(0, 4095));
            else if (pick < 90)
                do_write($urandom_range(0, (PAGES << SHIFT) - 1));
            else
                do_write($urandom());
        end else begin
            send(noise_req(vpwwt_pkg::OP_NOP));
        end
    endtask

    initial begin
        sb = new();
        calm = 1'b0;
        cycles = 0;
        out_stall = 0;
        n_sent = 0;
        n_lock = 0;
        n_unlock = 0;
        n_write = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_out_ready <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: clamping, start reset, bounds, empty pages, full slots
        do_lock(32'h0, 32'h0);
        do_lock(32'h0, 32'hFFFF_FFFF);
        do_lock(32'h0000_5000, 32'h0000_3000);
        do_lock(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        do_unlock(6'd1);
        do_unlock(6'd3);
        do_unlock(6'd63);
        do_write(32'hFFFF_FFFF);
        do_write(32'h0080_0000);
        do_write(32'h007F_FFFF);
        do_write(32'h0000_0000);
        do_write(32'h0000_0FFF);
        for (int k = 0; k <= SLOTS; k++)
            do_lock(32'h0000_5000 + k, 32'h0000_5FFF - k);
        send(noise_req(vpwwt_pkg::OP_NOP));
        do_write(32'h0000_5123);
        drain();

        // Random traffic with calm stretches and a handle-exhaustion burst
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 60 == 30) calm = ~calm;
            if (i == 200) begin
                drain();
                for (int k = 0; k < HANDLES + 2; k++)
                    do_lock(32'((200 + k) << SHIFT), 32'((200 + k) << SHIFT) | 32'hFFF);
            end
            random_request();
        end
        calm = 1'b0;
        drain();

        $display("sent %0d requests (%0d lock, %0d unlock, %0d write), checked %0d results",
                 n_sent, n_lock, n_unlock, n_write, sb.n_results);
        $display("writes reported %0d watched handles", sb.n_hits);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
